[hw/rtl/button_debounce_edge_long_press_assert.svh]
// assertion macros for the button debouncer checker
`ifndef BUTTON_DEBOUNCE_EDGE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_EDGE_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BDELP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDELP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bdelp_pkg.sv]
// shared types and constants for the button debouncer
package bdelp_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W          = 16;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 32;

  localparam logic              PULL_UP_RST    = 1'b1;
  localparam logic [CFG_W-1:0]  DEBOUNCE_RST   = 16'd5;
  localparam logic [CFG_W-1:0]  LONG_PRESS_RST = 16'd300;

  typedef enum logic [1:0] {
    REG_PULL_UP_MODE     = 2'd0,
    REG_DEBOUNCE_TICKS   = 2'd1,
    REG_LONG_PRESS_TICKS = 2'd2
  } bdelp_reg_t;

  typedef struct packed {
    logic             pull_up_mode;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } bdelp_cfg_t;

  typedef struct packed {
    logic pressed;
    logic press_pulse;
    logic long_press;
  } bdelp_result_t;

endpackage

[hw/rtl/bdelp_core.sv]
// per-tick debounce, press edge and long press state update
module bdelp_core
  import bdelp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          pin_level,
  input  bdelp_cfg_t    cfg,
  output bdelp_result_t result
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  prev_raw;
  logic [TIMER_BITS-1:0] stable_count;
  logic                  debounced;
  logic                  edge_seen;
  logic                  holding;
  logic [TIMER_BITS-1:0] held_count;

  logic                  raw;
  logic [TIMER_BITS-1:0] stable_count_next;
  logic                  debounced_next;
  logic                  holding_start;
  logic [TIMER_BITS-1:0] held_base;
  logic                  long_hit;
  logic                  holding_next;
  logic [TIMER_BITS-1:0] held_count_next;

  always_comb begin
    raw = cfg.pull_up_mode ? ~pin_level : pin_level;
    if (raw != prev_raw) begin
      stable_count_next = '0;
    end else if (&stable_count) begin
      stable_count_next = stable_count;
    end else begin
      stable_count_next = stable_count + 1'b1;
    end
    debounced_next = (CW'(stable_count_next) > CW'(cfg.debounce_ticks)) ? raw : debounced;

    // new measurement starts on a pressed tick with no measurement running
    holding_start = debounced_next & ~holding;
    held_base     = holding_start ? '0 : held_count;
    long_hit      = debounced_next && (CW'(held_base) >= CW'(cfg.long_press_ticks));
    holding_next  = debounced_next & ~long_hit;
    if (debounced_next && !long_hit && !(&held_base)) begin
      held_count_next = held_base + 1'b1;
    end else begin
      held_count_next = held_base;
    end

    result.pressed     = debounced_next;
    result.press_pulse = debounced_next & ~edge_seen;
    result.long_press  = long_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw     <= 1'b0;
      stable_count <= '0;
      debounced    <= 1'b0;
      edge_seen    <= 1'b0;
      holding      <= 1'b0;
      held_count   <= '0;
    end else if (step) begin
      prev_raw     <= raw;
      stable_count <= stable_count_next;
      debounced    <= debounced_next;
      edge_seen    <= debounced_next;
      holding      <= holding_next;
      held_count   <= held_count_next;
    end
  end

endmodule

[hw/rtl/button_debounce_edge_long_press.sv]
// button debouncer with press edge and repeating long press, top level
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  pin_level
//  out      output     out_valid/out_stall pressed, press_pulse, long_press
//  cfg      apb        psel/penable/pready paddr, pwdata, prdata
//
//  one beat per cycle in while in_stall is low, one result beat per input beat, registered in the cycle after it
//  state update is a single compare-and-increment pass between state and output registers
//  in_stall is high only while a held result waits on out_stall
//  synchronous reset clears state and loads register defaults
module button_debounce_edge_long_press
  import bdelp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              pin_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              pressed,
  output logic              press_pulse,
  output logic              long_press,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  bdelp_cfg_t    cfg;
  bdelp_result_t tick_result;
  bdelp_result_t out_result;
  bdelp_reg_t    reg_sel;
  logic          in_accept;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = bdelp_reg_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pull_up_mode     <= PULL_UP_RST;
      cfg.debounce_ticks   <= DEBOUNCE_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_PULL_UP_MODE:     cfg.pull_up_mode     <= pwdata[0];
        REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PULL_UP_MODE:     prdata = APB_DW'(cfg.pull_up_mode);
      REG_DEBOUNCE_TICKS:   prdata = APB_DW'(cfg.debounce_ticks);
      REG_LONG_PRESS_TICKS: prdata = APB_DW'(cfg.long_press_ticks);
      default:              prdata = '0;
    endcase
  end

  bdelp_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_accept),
    .pin_level(pin_level),
    .cfg      (cfg),
    .result   (tick_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_result <= tick_result;
    end
  end

  assign pressed     = out_result.pressed;
  assign press_pulse = out_result.press_pulse;
  assign long_press  = out_result.long_press;

endmodule

[hw/rtl/bdelp_checker.sv]
// port-level checker for the button debouncer, bound to the top level
`include "button_debounce_edge_long_press_assert.svh"

module bdelp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic pressed,
  input logic press_pulse,
  input logic long_press
);

  `BDELP_ASSERT_NOW(a_pulse_pressed, clk, rst, out_valid && press_pulse, pressed, "press pulse without pressed")
  `BDELP_ASSERT_NOW(a_long_pressed, clk, rst, out_valid && long_press, pressed, "long press without pressed")
  `BDELP_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "input stalled with free output")
  `BDELP_ASSERT_NEXT(a_beat_out, clk, rst, in_valid && !in_stall, out_valid, "accepted beat gave no result")

endmodule

bind button_debounce_edge_long_press bdelp_checker u_bdelp_checker (.*);

[tb/debounce_checker.sv]
// predicts the debouncer result for each accepted pin beat and compares the output beats
module debounce_checker
  import bdelp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              pin_level,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              pressed,
  input  logic              press_pulse,
  input  logic              long_press,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                flags_pending
);
  localparam logic [TIMER_BITS_DEF-1:0] COUNT_TOP = '1;

  bdelp_cfg_t                cfg;
  logic                      last_raw;
  logic [TIMER_BITS_DEF-1:0] stable_ticks;
  logic                      db_pressed;
  logic                      pulse_done;
  logic                      timing_hold;
  logic [TIMER_BITS_DEF-1:0] hold_ticks;
  bdelp_result_t             expected_flags[$];
  int                        errors = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic bdelp_result_t next_button_flags(input logic pin);
    bdelp_result_t r;
    logic raw;
    r = '0;
    raw = cfg.pull_up_mode ? ~pin : pin;
    if (raw != last_raw) stable_ticks = '0;
    else if (stable_ticks != COUNT_TOP) stable_ticks = stable_ticks + 1'b1;
    if (stable_ticks > cfg.debounce_ticks) db_pressed = raw;
    last_raw = raw;
    if (db_pressed) begin
      if (!pulse_done) begin
        pulse_done = 1'b1;
        r.press_pulse = 1'b1;
      end
    end else begin
      pulse_done = 1'b0;
    end
    if (db_pressed && !timing_hold) begin
      timing_hold = 1'b1;
      hold_ticks = '0;
    end
    if (!db_pressed) timing_hold = 1'b0;
    if (timing_hold) begin
      if (hold_ticks >= cfg.long_press_ticks) begin
        timing_hold = 1'b0;
        r.long_press = 1'b1;
      end else if (hold_ticks != COUNT_TOP) begin
        hold_ticks = hold_ticks + 1'b1;
      end
    end
    r.pressed = db_pressed;
    return r;
  endfunction

  always @(posedge clk) begin
    bdelp_result_t want;
    if (rst) begin
      cfg.pull_up_mode = PULL_UP_RST;
      cfg.debounce_ticks = DEBOUNCE_RST;
      cfg.long_press_ticks = LONG_PRESS_RST;
      last_raw = 1'b0;
      stable_ticks = '0;
      db_pressed = 1'b0;
      pulse_done = 1'b0;
      timing_hold = 1'b0;
      hold_ticks = '0;
      expected_flags.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_PULL_UP_MODE:     cfg.pull_up_mode = pwdata[0];
          REG_DEBOUNCE_TICKS:   cfg.debounce_ticks = pwdata[CFG_W-1:0];
          REG_LONG_PRESS_TICKS: cfg.long_press_ticks = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_flags.push_back(next_button_flags(pin_level));
      if (out_valid && !out_stall) begin
        if (expected_flags.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_flags.pop_front();
          if (pressed !== want.pressed)
            report_mismatch($sformatf("pressed expected %0b got %0b", want.pressed, pressed));
          if (press_pulse !== want.press_pulse)
            report_mismatch($sformatf("press_pulse expected %0b got %0b",
                                      want.press_pulse, press_pulse));
          if (long_press !== want.long_press)
            report_mismatch($sformatf("long_press expected %0b got %0b",
                                      want.long_press, long_press));
        end
      end
    end
    flags_pending <= expected_flags.size();
  end

endmodule

[tb/testbench.sv]
// top of the debouncer testbench: clock, reset, pin stimulus, output stalls and verdict
module testbench;
  import bdelp_pkg::*;

  localparam int         IDLE_LIMIT      = 2000;
  localparam int         HOLD_OFF_CYCLES = 60;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              pin_level = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic              pressed;
  logic              press_pulse;
  logic              long_press;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int flags_pending;
  int quiet_cycles = 0;
  int ticks_sent   = 0;
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  bit cur_pull_up  = 1'b1;
  int cur_deb      = 5;
  int cur_lpt      = 300;

  button_debounce_edge_long_press dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pin_level(pin_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .pressed(pressed), .press_pulse(press_pulse), .long_press(long_press),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  debounce_checker result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pin_level(pin_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .pressed(pressed), .press_pulse(press_pulse), .long_press(long_press),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .flags_pending(flags_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_tick(input logic pin);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (flags_pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits carry junk that the block has to drop
  task automatic set_config(input logic pu, input logic [15:0] deb, input logic [15:0] lpt);
    logic [31:0] junk;
    wait_drained();
    junk = $urandom();
    write_reg(REG_PULL_UP_MODE, {junk[31:1], pu});
    junk = $urandom();
    write_reg(REG_DEBOUNCE_TICKS, {junk[31:16], deb});
    junk = $urandom();
    write_reg(REG_LONG_PRESS_TICKS, {junk[31:16], lpt});
    cur_pull_up = pu;
    cur_deb = int'(deb);
    cur_lpt = int'(lpt);
  endtask

  // bounce, hold, bounce, release
  task automatic press_cycle();
    logic down;
    int hold;
    int rel;
    down = ~cur_pull_up;
    repeat ($urandom_range(0, 4)) send_tick(1'($urandom_range(0, 1)));
    hold = $urandom_range(1, cur_deb + 2 * cur_lpt + 6);
    if (hold > 40) hold = $urandom_range(1, 40);
    repeat (hold) send_tick(down);
    repeat ($urandom_range(0, 4)) send_tick(1'($urandom_range(0, 1)));
    rel = $urandom_range(1, cur_deb + 6);
    if (rel > 40) rel = $urandom_range(1, 40);
    repeat (rel) send_tick(~down);
  endtask

  task automatic run_phase(input int budget, input logic pu, input logic [15:0] deb,
                           input logic [15:0] lpt, input bit with_hold);
    int start;
    set_config(pu, deb, lpt);
    no_idle = ($urandom_range(0, 3) == 0);
    if (with_hold) hold_request = 1'b1;
    start = ticks_sent;
    while (ticks_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        press_cycle();
      end
    end
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
        @(posedge clk);
      end else begin
        n = idle_cycles();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] deb;
    logic [15:0] lpt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, pull-up: pin low debounces into a press, then a release starts
    repeat (8) send_tick(1'b0);
    repeat (2) send_tick(1'b1);

    // zero debounce length and zero long press length: long press on every pressed beat
    set_config(1'b0, 16'd0, 16'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // write to an unmapped register index must leave the settings alone
    wait_drained();
    write_reg(REG_UNUSED, $urandom());
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    run_phase(40, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(110, 1'b1, 16'd0, 16'd0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 5))
        0:       deb = 16'd0;
        1:       deb = 16'd1;
        default: deb = 16'($urandom_range(2, 8));
      endcase
      lpt = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 15));
      run_phase(110, 1'($urandom_range(0, 1)), deb, lpt, i == 2);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bdelp_pkg.sv
hw/rtl/bdelp_core.sv
hw/rtl/button_debounce_edge_long_press.sv
hw/rtl/bdelp_checker.sv
tb/debounce_checker.sv
tb/testbench.sv
